// File: rtl/core/wsd_pkg.sv
// shared types and constants for the websocket frame deframer
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LEN7   = 3'd1,
    PH_LENX   = 3'd2,
    PH_MASK   = 3'd3,
    PH_DATA   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_RESERVED = 3'd0,
    ERR_OPCODE   = 3'd1,
    ERR_UNMASKED = 3'd2,
    ERR_CONTROL  = 3'd3,
    ERR_TOO_LONG = 3'd4
  } err_code_t;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1048576;
  localparam logic [7:0]  RSV_MASK        = 8'h70;
  localparam logic [6:0]  LEN_EXT16       = 7'd126;
  localparam logic [6:0]  LEN_EXT64       = 7'd127;
  localparam logic [63:0] CTRL_MAX_LEN    = 64'd125;
  localparam logic [2:0]  EXT16_LEFT      = 3'd1;
  localparam logic [2:0]  EXT64_LEFT      = 3'd7;
  localparam logic [1:0]  MASK_LAST_IDX   = 2'd3;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [3:0]  frame_opcode;
    logic        final_fragment;
    logic        last_of_frame;
    logic [31:0] frame_length;
    err_code_t   error_code;
  } result_t;

endpackage

// File: rtl/core/websocket_frame_deframer.sv
// websocket client frame deframer: header parse, unmasking and error checks
// each result is registered in the output register, or in the skid entry
// throughput: one byte per cycle while in_ready is high; a two-entry output
// register and skid stage keep in_ready high while a single result waits for out_ready
// reset: synchronous active-low rst_n returns to the header phase, clears the
// error latch and both output entries, and loads max_len_r with 1048576
module websocket_frame_deframer #(
  parameter int LENGTH_COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [3:0]  out_frame_opcode,
  output logic        out_final_fragment,
  output logic        out_last_of_frame,
  output logic [31:0] out_frame_length,
  output logic [2:0]  out_error_code
);

  localparam logic [63:0] CNT_LIMIT = (LENGTH_COUNT_BITS >= 64) ? {64{1'b1}} :
                                      ((64'd1 << LENGTH_COUNT_BITS) - 64'd1);

  wsd_pkg::phase_t  phase_r, phase_nxt;
  logic             fin_r, fin_nxt;
  logic [3:0]       opcode_r, opcode_nxt;
  logic [63:0]      len_r, len_nxt;
  logic [2:0]       left_r, left_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [1:0]       seen_r, seen_nxt;
  logic [LENGTH_COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic             err_r, err_nxt;
  logic [31:0]      max_len_r;

  wsd_pkg::result_t res;
  logic             res_v;
  wsd_pkg::result_t out_r, skid_r;
  logic             out_v_r, skid_v_r;

  logic        in_fire;
  logic [7:0]  b;
  logic [63:0] len_cand;
  logic [63:0] limit;
  logic        ctrl_bad;
  logic        too_long;
  logic        opcode_ok;
  logic [7:0]  key_byte;
  logic        last;

  assign in_ready = !skid_v_r;
  assign in_fire  = in_valid && in_ready;
  assign b        = in_data_byte;
  assign cnt_inc  = cnt_r + 1'b1;

  // full length as it stands once this byte is folded in
  assign len_cand = (phase_r == wsd_pkg::PH_LENX) ? {len_r[55:0], b} : {57'd0, b[6:0]};
  assign limit    = ({32'd0, max_len_r} > CNT_LIMIT) ? CNT_LIMIT : {32'd0, max_len_r};
  assign ctrl_bad = opcode_r[3] && (!fin_r || (len_cand > wsd_pkg::CTRL_MAX_LEN));
  assign too_long = len_cand > limit;
  assign opcode_ok = (b[3:0] <= 4'd2) || ((b[3:0] >= 4'd8) && (b[3:0] <= 4'd10));
  assign last      = (64'(cnt_inc) == len_r);

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    len_nxt    = len_r;
    left_nxt   = left_r;
    key_nxt    = key_r;
    seen_nxt   = seen_r;
    cnt_nxt    = cnt_r;
    err_nxt    = err_r;
    res_v      = 1'b0;
    res        = '0;
    res.kind       = wsd_pkg::KIND_BYTE;
    res.error_code = wsd_pkg::ERR_RESERVED;
    if (in_fire && !err_r) begin
      case (phase_r)
        wsd_pkg::PH_HEADER: begin
          fin_nxt    = b[7];
          opcode_nxt = b[3:0];
          len_nxt    = '0;
          cnt_nxt    = '0;
          if ((b & wsd_pkg::RSV_MASK) != 8'd0) begin
            err_nxt        = 1'b1;
            res_v          = 1'b1;
            res.kind       = wsd_pkg::KIND_ERROR;
            res.error_code = wsd_pkg::ERR_RESERVED;
          end else if (!opcode_ok) begin
            err_nxt        = 1'b1;
            res_v          = 1'b1;
            res.kind       = wsd_pkg::KIND_ERROR;
            res.error_code = wsd_pkg::ERR_OPCODE;
          end else begin
            phase_nxt = wsd_pkg::PH_LEN7;
          end
        end
        wsd_pkg::PH_LEN7, wsd_pkg::PH_LENX: begin
          len_nxt = len_cand;
          if (phase_r == wsd_pkg::PH_LEN7 && !b[7]) begin
            err_nxt        = 1'b1;
            res_v          = 1'b1;
            res.kind       = wsd_pkg::KIND_ERROR;
            res.error_code = wsd_pkg::ERR_UNMASKED;
          end else if (phase_r == wsd_pkg::PH_LEN7 && b[6:0] == wsd_pkg::LEN_EXT16) begin
            len_nxt   = '0;
            left_nxt  = wsd_pkg::EXT16_LEFT;
            phase_nxt = wsd_pkg::PH_LENX;
          end else if (phase_r == wsd_pkg::PH_LEN7 && b[6:0] == wsd_pkg::LEN_EXT64) begin
            len_nxt   = '0;
            left_nxt  = wsd_pkg::EXT64_LEFT;
            phase_nxt = wsd_pkg::PH_LENX;
          end else if (phase_r == wsd_pkg::PH_LENX && left_r != 3'd0) begin
            left_nxt = left_r - 3'd1;
          end else if (ctrl_bad) begin
            err_nxt        = 1'b1;
            res_v          = 1'b1;
            res.kind       = wsd_pkg::KIND_ERROR;
            res.error_code = wsd_pkg::ERR_CONTROL;
          end else if (too_long) begin
            err_nxt        = 1'b1;
            res_v          = 1'b1;
            res.kind       = wsd_pkg::KIND_ERROR;
            res.error_code = wsd_pkg::ERR_TOO_LONG;
          end else begin
            phase_nxt = wsd_pkg::PH_MASK;
            seen_nxt  = '0;
            key_nxt   = '0;
          end
        end
        wsd_pkg::PH_MASK: begin
          key_nxt = {key_r[23:0], b};
          if (seen_r != wsd_pkg::MASK_LAST_IDX) begin
            seen_nxt = seen_r + 2'd1;
          end else begin
            seen_nxt = '0;
            cnt_nxt  = '0;
            if (len_r == 64'd0) begin
              phase_nxt         = wsd_pkg::PH_HEADER;
              res_v             = 1'b1;
              res.kind          = wsd_pkg::KIND_EMPTY;
              res.last_of_frame = 1'b1;
            end else begin
              phase_nxt = wsd_pkg::PH_DATA;
            end
          end
        end
        wsd_pkg::PH_DATA: begin
          cnt_nxt = cnt_inc;
          if (last) begin
            phase_nxt = wsd_pkg::PH_HEADER;
          end
          res_v             = 1'b1;
          res.kind          = wsd_pkg::KIND_BYTE;
          res.payload_byte  = b ^ key_byte;
          res.last_of_frame = last;
          res.frame_length  = len_r[31:0];
        end
        default: begin
          phase_nxt = wsd_pkg::PH_HEADER;
        end
      endcase
    end
    res.frame_opcode   = opcode_nxt;
    res.final_fragment = fin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= wsd_pkg::PH_HEADER;
      fin_r     <= 1'b0;
      opcode_r  <= '0;
      len_r     <= '0;
      left_r    <= '0;
      key_r     <= '0;
      seen_r    <= '0;
      cnt_r     <= '0;
      err_r     <= 1'b0;
      max_len_r <= wsd_pkg::MAX_PAYLOAD_RST;
    end else begin
      phase_r  <= phase_nxt;
      fin_r    <= fin_nxt;
      opcode_r <= opcode_nxt;
      len_r    <= len_nxt;
      left_r   <= left_nxt;
      key_r    <= key_nxt;
      seen_r   <= seen_nxt;
      cnt_r    <= cnt_nxt;
      err_r    <= err_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

  // output word register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= res_v;
      end
    end else if (res_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else begin
        out_r <= res;
      end
    end else if (res_v) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_kind           = out_r.kind;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_frame_opcode   = out_r.frame_opcode;
  assign out_final_fragment = out_r.final_fragment;
  assign out_last_of_frame  = out_r.last_of_frame;
  assign out_frame_length   = out_r.frame_length;
  assign out_error_code     = out_r.error_code;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held while output register empty");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("error latch cleared without reset");

  a_err_word_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.kind == wsd_pkg::KIND_ERROR) |-> err_r)
    else $error("error word shown but error latch not set");

  a_data_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wsd_pkg::PH_DATA) |-> (len_r != 64'd0 && len_r[63:32] == 32'd0))
    else $error("payload phase with zero or oversized length");

  a_no_word_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r && in_fire) |-> !res_v)
    else $error("word produced after error latched");

endmodule
